// File: sv/mwe_pkg.sv
package mwe_pkg;

  localparam int MAX_BUTTONS = 32;
  localparam int MAX_DELTA   = 64;
  localparam int CLICK_CAP   = 64;

  localparam int BTN_W    = 6;
  localparam int TRAVEL_W = 18;
  localparam int CNT_W    = $clog2(CLICK_CAP + 1);
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLED    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EMU_BUTTON = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INERTIA    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_UP       = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_X_DOWN     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_Y_UP       = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_Y_DOWN     = 4'd7;

  localparam logic [BTN_W-1:0] RST_EMU_BUTTON = 6'd4;
  localparam logic [15:0]      RST_INERTIA    = 16'd10;
  localparam logic [15:0]      RST_TIMEOUT    = 16'd200;
  localparam logic [BTN_W-1:0] RST_X_UP       = 6'd0;
  localparam logic [BTN_W-1:0] RST_X_DOWN     = 6'd0;
  localparam logic [BTN_W-1:0] RST_Y_UP       = 6'd4;
  localparam logic [BTN_W-1:0] RST_Y_DOWN     = 6'd5;

  localparam logic signed [7:0] DELTA_HI = 8'(MAX_DELTA);
  localparam logic signed [7:0] DELTA_LO = 8'(-MAX_DELTA);

  localparam logic signed [TRAVEL_W-1:0] TRAVEL_MAX = {1'b0, {(TRAVEL_W-1){1'b1}}};
  localparam logic signed [TRAVEL_W-1:0] TRAVEL_MIN = {1'b1, {(TRAVEL_W-1){1'b0}}};

endpackage

// File: sv/mouse_wheel_emulation.sv
// An event accepted in IDLE is evaluated in EVAL; the word for a button event, or for
// motion that is not scrolled, is registered there once the output slot is free;
// scrolled motion on a configured axis goes on through START and LOOP, which issue its
// wheel clicks (at most 64), stepped by the shared travel adder, one click per cycle
// while the output is taken. One event at a time: the next is taken only back in IDLE.
// Reset: synchronous active-low rst_n restores register defaults, clears state.
module mouse_wheel_emulation import mwe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_command,
  input  logic [7:0]            in_event_button,
  input  logic                  in_button_pressed,
  input  logic [1:0]            in_axis_code,
  input  logic signed [7:0]     in_motion_delta,
  input  logic [31:0]           in_now_ms,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_consumed,
  output logic                  out_click_valid,
  output logic [BTN_W-1:0]      out_click_button,
  output logic                  out_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {IDLE, EVAL, START, LOOP} state_t;

  state_t state_r;

  logic             enabled_r;
  logic [BTN_W-1:0] emu_button_r, x_up_r, x_down_r, y_up_r, y_down_r;
  logic [15:0]      inertia_r, timeout_r;

  logic                       held_r;
  logic [31:0]                deadline_r;
  logic signed [TRAVEL_W-1:0] x_travel_r, y_travel_r;

  logic              cmd_r, pressed_r;
  logic [7:0]        btn_r;
  logic [1:0]        axis_r;
  logic signed [7:0] delta_r;
  logic [31:0]       now_r;

  logic signed [TRAVEL_W-1:0] t_r;
  logic                       neg_r, is_x_r, pend_r;
  logic [BTN_W-1:0]           wheel_btn_r;
  logic [CNT_W-1:0]           cnt_r;

  logic             out_valid_r, out_consumed_r, out_click_valid_r, out_last_r;
  logic [BTN_W-1:0] out_click_button_r;

  logic                       slot_free;
  logic                       b_ok;
  logic                       emu_match;
  logic [31:0]                dl_diff;
  logic                       before_dl;
  logic [15:0]                step;
  logic signed [TRAVEL_W:0]   start_sum;
  logic signed [TRAVEL_W-1:0] start_t;
  logic signed [TRAVEL_W:0]   loop_sum;
  logic                       loop_more;
  logic signed [7:0]          delta_sat;
  logic                       axis_ok;

  assign in_ready  = (state_r == IDLE);
  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_consumed     = out_consumed_r;
  assign out_click_valid  = out_click_valid_r;
  assign out_click_button = out_click_button_r;
  assign out_last         = out_last_r;

  always_comb begin
    b_ok      = (cfg_data[BTN_W-1:0] <= BTN_W'(MAX_BUTTONS));
    emu_match = (btn_r == {2'b00, emu_button_r});
    dl_diff   = deadline_r - now_r;
    before_dl = (dl_diff != 32'd0) && !dl_diff[31];
    step      = (inertia_r == 16'd0) ? 16'd1 : inertia_r;
    axis_ok   = ((axis_r == 2'd0) && (x_up_r != '0)) || ((axis_r == 2'd1) && (y_up_r != '0));

    if (in_motion_delta > DELTA_HI) begin
      delta_sat = DELTA_HI;
    end else if (in_motion_delta < DELTA_LO) begin
      delta_sat = DELTA_LO;
    end else begin
      delta_sat = in_motion_delta;
    end

    // clamp travel plus delta into the travel range
    start_sum = (is_x_r ? {x_travel_r[TRAVEL_W-1], x_travel_r}
                        : {y_travel_r[TRAVEL_W-1], y_travel_r})
              + {{(TRAVEL_W-7){delta_r[7]}}, delta_r};
    if (start_sum > $signed({TRAVEL_MAX[TRAVEL_W-1], TRAVEL_MAX})) begin
      start_t = TRAVEL_MAX;
    end else if (start_sum < $signed({TRAVEL_MIN[TRAVEL_W-1], TRAVEL_MIN})) begin
      start_t = TRAVEL_MIN;
    end else begin
      start_t = start_sum[TRAVEL_W-1:0];
    end

    // step travel toward zero; the sign of the result tells whether |t| > step
    loop_sum = neg_r ? ({t_r[TRAVEL_W-1], t_r} + $signed({3'b000, step}))
                     : ({t_r[TRAVEL_W-1], t_r} - $signed({3'b000, step}));
    loop_more = (neg_r ? loop_sum[TRAVEL_W] : (!loop_sum[TRAVEL_W] && (loop_sum != '0)))
              && (cnt_r < CNT_W'(CLICK_CAP));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= IDLE;
      enabled_r    <= 1'b0;
      emu_button_r <= RST_EMU_BUTTON;
      inertia_r    <= RST_INERTIA;
      timeout_r    <= RST_TIMEOUT;
      x_up_r       <= RST_X_UP;
      x_down_r     <= RST_X_DOWN;
      y_up_r       <= RST_Y_UP;
      y_down_r     <= RST_Y_DOWN;
      held_r       <= 1'b0;
      deadline_r   <= 32'd0;
      x_travel_r   <= '0;
      y_travel_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_ENABLED:    enabled_r <= cfg_data[0];
          REG_EMU_BUTTON: if (b_ok) emu_button_r <= cfg_data[BTN_W-1:0];
          REG_INERTIA:    inertia_r <= cfg_data;
          REG_TIMEOUT:    timeout_r <= cfg_data;
          REG_X_UP:       if (b_ok) x_up_r <= cfg_data[BTN_W-1:0];
          REG_X_DOWN:     if (b_ok) x_down_r <= cfg_data[BTN_W-1:0];
          REG_Y_UP:       if (b_ok) y_up_r <= cfg_data[BTN_W-1:0];
          REG_Y_DOWN:     if (b_ok) y_down_r <= cfg_data[BTN_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        IDLE: begin
          if (in_valid) begin
            cmd_r     <= in_command;
            btn_r     <= in_event_button;
            pressed_r <= in_button_pressed;
            axis_r    <= in_axis_code;
            delta_r   <= delta_sat;
            now_r     <= in_now_ms;
            is_x_r    <= (in_axis_code == 2'd0);
            state_r   <= EVAL;
          end
        end
        EVAL: begin
          if (slot_free) begin
            // default: one word without a click
            out_valid_r        <= 1'b1;
            out_consumed_r     <= 1'b0;
            out_click_valid_r  <= 1'b0;
            out_click_button_r <= '0;
            out_last_r         <= 1'b1;
            state_r            <= IDLE;
            if (enabled_r && !cmd_r && emu_match) begin
              out_consumed_r <= 1'b1;
              held_r         <= pressed_r;
              if (pressed_r) begin
                deadline_r <= {16'd0, timeout_r} + now_r;
              end else if (before_dl) begin
                out_click_valid_r  <= 1'b1;
                out_click_button_r <= btn_r[BTN_W-1:0];
              end
            end else if (enabled_r && cmd_r && (held_r || emu_button_r == '0)) begin
              out_consumed_r <= 1'b1;
              if (!(emu_button_r != '0 && before_dl) && axis_ok) begin
                // hold the output word; the click loop issues it
                out_valid_r <= 1'b0;
                state_r     <= START;
              end
            end
          end
        end
        START: begin
          t_r    <= start_t;
          neg_r  <= start_t[TRAVEL_W-1];
          cnt_r  <= '0;
          pend_r <= 1'b0;
          if (is_x_r) begin
            wheel_btn_r <= start_t[TRAVEL_W-1] ? x_up_r : x_down_r;
          end else begin
            wheel_btn_r <= start_t[TRAVEL_W-1] ? y_up_r : y_down_r;
          end
          state_r <= LOOP;
        end
        LOOP: begin
          if (slot_free) begin
            if (loop_more) begin
              t_r    <= loop_sum[TRAVEL_W-1:0];
              cnt_r  <= cnt_r + CNT_W'(1);
              pend_r <= 1'b1;
              if (pend_r) begin
                out_valid_r        <= 1'b1;
                out_consumed_r     <= 1'b1;
                out_click_valid_r  <= 1'b1;
                out_click_button_r <= wheel_btn_r;
                out_last_r         <= 1'b0;
              end
            end else begin
              out_valid_r        <= 1'b1;
              out_consumed_r     <= 1'b1;
              out_click_valid_r  <= pend_r;
              out_click_button_r <= pend_r ? wheel_btn_r : '0;
              out_last_r         <= 1'b1;
              // write travel back; any click clears the other axis
              if (is_x_r) begin
                x_travel_r <= t_r;
                if (cnt_r != '0) y_travel_r <= '0;
              end else begin
                y_travel_r <= t_r;
                if (cnt_r != '0) x_travel_r <= '0;
              end
              state_r <= IDLE;
            end
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

endmodule
